[sv/pol_pkg.sv]
// Shared definitions for the positional ordered list block.
// Holds the request codes, the cell command codes and the default sizes.
// No dependencies.
package pol_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int REQ_W          = 3;
    localparam int POS_W          = 8;
    localparam int VALUE_W        = 32;
    localparam int COUNT_OUT_W    = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_FIND   = 3'd2,
        REQ_READ   = 3'd3,
        REQ_APPEND = 3'd4
    } req_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

endpackage

[sv/positional_ordered_list.sv]
// Top level of the positional ordered list: a chain of pol_cell entries and the sequencer.
// Depends on pol_pkg, pol_cell and pol_ctrl.
//
// The list keeps up to CAPACITY values in order, one value per cell of a chain,
// position 1 in the cell next to the sequencer. Insert and append move every
// later entry back by one cell at once. Find, read and delete rotate the whole
// list once past the head cell, one cell step per clock; delete drops the chosen
// entry when it reaches the head. A request that fails its position or fill
// check is answered without a rotation. The response word sits in an output
// register, and the next request is taken once no rotation is running and that
// register is empty or being taken. No clearing pass follows reset: the list
// starts empty.
module positional_ordered_list import pol_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  logic [REQ_W-1:0]          req_type,
    input  logic [POS_W-1:0]          position,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output logic                      ok,
    output logic signed [VALUE_W-1:0] result_value,
    output logic [COUNT_OUT_W-1:0]    found_position,
    output logic [COUNT_OUT_W-1:0]    entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    cell_op_t              cell_op;
    logic [IDX_W-1:0]      cell_idx;
    logic [DATA_WIDTH-1:0] cell_val;
    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

    pol_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .ok             (ok),
        .result_value   (result_value),
        .found_position (found_position),
        .entry_count    (entry_count),
        .head           (cell_q[0]),
        .cell_op        (cell_op),
        .cell_idx       (cell_idx),
        .cell_val       (cell_val)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = '0;
        end
        else
        begin : g_mid_l
            assign left_data = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_mid_r
            assign right_data = cell_q[i+1];
        end

        pol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (i)
        ) u_cell (
            .clk   (clk),
            .op    (cell_op),
            .idx   (cell_idx),
            .din   (cell_val),
            .left  (left_data),
            .right (right_data),
            .head  (cell_q[0]),
            .q     (cell_q[i])
        );
    end

endmodule

[sv/pol_cell.sv]
// One storage cell of the list chain: holds a single entry.
// Depends on pol_pkg for the cell command codes.
module pol_cell import pol_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX_W      = 6,
    parameter int CELL_IDX   = 0
)
(
    input  logic                  clk,
    input  cell_op_t              op,
    input  logic [IDX_W-1:0]      idx,
    input  logic [DATA_WIDTH-1:0] din,
    input  logic [DATA_WIDTH-1:0] left,
    input  logic [DATA_WIDTH-1:0] right,
    input  logic [DATA_WIDTH-1:0] head,
    output logic [DATA_WIDTH-1:0] q
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INS:
            begin
                // Cells behind the insert point move back by one.
                if (MY_IDX > idx)
                begin
                    data_next = left;
                end
                else if (MY_IDX == idx)
                begin
                    data_next = din;
                end
            end
            CELL_DEL:
            begin
                if (MY_IDX >= idx)
                begin
                    data_next = right;
                end
            end
            CELL_ROT:
            begin
                // Rotation: every live entry moves forward, the head wraps to the tail.
                if (MY_IDX < idx)
                begin
                    data_next = right;
                end
                else if (MY_IDX == idx)
                begin
                    data_next = head;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

[sv/pol_ctrl.sv]
// Request sequencer for the positional ordered list: count, scans and response word.
// Depends on pol_pkg; drives the command broadcast of the pol_cell chain.
module pol_ctrl import pol_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CNT_W      = 7,
    parameter int IDX_W      = 6
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [POS_W-1:0]        position,
    input  logic signed [VALUE_W-1:0] value,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    ok,
    output logic signed [VALUE_W-1:0] result_value,
    output logic [COUNT_OUT_W-1:0]  found_position,
    output logic [COUNT_OUT_W-1:0]  entry_count,
    input  logic [DATA_WIDTH-1:0]   head,
    output cell_op_t                cell_op,
    output logic [IDX_W-1:0]        cell_idx,
    output logic [DATA_WIDTH-1:0]   cell_val
);

    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     rsp_valid_reg;
    logic                     ok_reg;
    logic [VALUE_W-1:0]       rv_reg;
    logic [COUNT_OUT_W-1:0]   fp_reg;
    logic [CNT_W-1:0]         step_reg;
    logic [CNT_W-1:0]         target_reg;
    logic                     hit_reg;
    logic                     drop_reg;
    req_t                     mode_reg;
    logic [DATA_WIDTH-1:0]    find_val_reg;

    req_t                     req;
    logic                     accept;
    logic [DATA_WIDTH-1:0]    store_val;
    logic [CMP_W-1:0]         pos_w;
    logic [CMP_W-1:0]         cnt_w;
    logic [POS_W-1:0]         pos_m1;
    logic                     not_full;
    logic                     ins_ok;
    logic                     at_ok;
    logic [CNT_W-1:0]         count_m1;
    logic [CNT_W-1:0]         count_m2;
    logic [CNT_W-1:0]         step_inc;
    logic                     last_step;
    logic                     at_target;
    logic                     match_now;
    logic                     scan_start;
    logic                     rsp_set;

    assign req       = req_t'(req_type);
    assign store_val = DATA_WIDTH'($unsigned(value));
    assign pos_w     = CMP_W'(position);
    assign cnt_w     = CMP_W'(count_reg);
    assign pos_m1    = position - POS_W'(1);
    assign not_full  = cnt_w < CMP_W'(CAPACITY);
    assign ins_ok    = (position != '0) && (pos_w <= cnt_w + CMP_W'(1)) && not_full;
    assign at_ok     = (position != '0) && (pos_w <= cnt_w);
    assign count_m1  = count_reg - CNT_W'(1);
    assign count_m2  = count_reg - CNT_W'(2);
    assign step_inc  = step_reg + CNT_W'(1);
    assign last_step = (step_reg == count_m1);
    assign at_target = (step_reg == target_reg);
    assign match_now = (head == find_val_reg);

    // The input side opens only when the sequencer is idle and the response register is empty or emptying.
    assign req_stall = !((state_reg == ST_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = req_valid && !req_stall;

    // Find on a non-empty list, and read or delete at a valid position, need a scan.
    assign scan_start = accept && (((req == REQ_FIND) && (count_reg != '0)) ||
                        (((req == REQ_READ) || (req == REQ_DELETE)) && at_ok));
    assign rsp_set    = (state_reg == ST_SCAN) ? last_step : (accept && !scan_start);

    always_comb
    begin
        cell_op  = CELL_HOLD;
        cell_idx = IDX_W'(pos_m1);
        cell_val = store_val;
        if (state_reg == ST_SCAN)
        begin
            if ((mode_reg == REQ_DELETE) && at_target)
            begin
                // Dropping the head shifts everything forward and shortens the ring.
                cell_op  = CELL_DEL;
                cell_idx = '0;
            end
            else
            begin
                cell_op  = CELL_ROT;
                cell_idx = drop_reg ? IDX_W'(count_m2) : IDX_W'(count_m1);
            end
        end
        else if (accept)
        begin
            unique case (req)
                REQ_INSERT:
                begin
                    if (ins_ok)
                    begin
                        cell_op = CELL_INS;
                    end
                end
                REQ_APPEND:
                begin
                    if (not_full)
                    begin
                        cell_op  = CELL_INS;
                        cell_idx = IDX_W'(count_reg);
                    end
                end
                default:
                begin
                    cell_op = CELL_HOLD;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            rv_reg        <= '0;
            fp_reg        <= '0;
            hit_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            step_reg      <= '0;
            target_reg    <= '0;
            mode_reg      <= REQ_INSERT;
            find_val_reg  <= '0;
        end
        else
        begin
            if (rsp_set)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        ok_reg       <= ((req == REQ_INSERT) && ins_ok) ||
                                        ((req == REQ_APPEND) && not_full);
                        rv_reg       <= '0;
                        fp_reg       <= '0;
                        hit_reg      <= 1'b0;
                        drop_reg     <= 1'b0;
                        step_reg     <= '0;
                        mode_reg     <= req;
                        find_val_reg <= store_val;
                        target_reg   <= CNT_W'(pos_m1);
                        if (scan_start)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        unique case (req)
                            REQ_INSERT:
                            begin
                                if (ins_ok)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            REQ_APPEND:
                            begin
                                if (not_full)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    // Until a delete drops its entry, the head cell shows entry step_reg.
                    step_reg <= step_inc;
                    if ((mode_reg == REQ_FIND) && !hit_reg && match_now)
                    begin
                        hit_reg <= 1'b1;
                        fp_reg  <= COUNT_OUT_W'(step_inc);
                    end
                    if (((mode_reg == REQ_READ) || (mode_reg == REQ_DELETE)) && at_target)
                    begin
                        rv_reg <= VALUE_W'(head);
                    end
                    if ((mode_reg == REQ_DELETE) && at_target)
                    begin
                        drop_reg <= 1'b1;
                    end
                    if (last_step)
                    begin
                        state_reg <= ST_IDLE;
                        if (mode_reg == REQ_FIND)
                        begin
                            ok_reg <= hit_reg || match_now;
                        end
                        else
                        begin
                            ok_reg <= 1'b1;
                        end
                        if (mode_reg == REQ_DELETE)
                        begin
                            count_reg <= count_m1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign ok             = ok_reg;
    assign result_value   = $signed(rv_reg);
    assign found_position = fp_reg;
    assign entry_count    = COUNT_OUT_W'(count_reg);

endmodule

[sv/pol_check.sv]
// Port-level checks for positional_ordered_list, attached by the bind at the end.
// Depends on pol_pkg for the field widths.
module pol_check import pol_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_stall,
    input logic [REQ_W-1:0]          req_type,
    input logic [POS_W-1:0]          position,
    input logic signed [VALUE_W-1:0] value,
    input logic                      rsp_valid,
    input logic                      rsp_stall,
    input logic                      ok,
    input logic signed [VALUE_W-1:0] result_value,
    input logic [COUNT_OUT_W-1:0]    found_position,
    input logic [COUNT_OUT_W-1:0]    entry_count
);

    // A position is only reported for a successful find.
    a_found_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (found_position != '0) |-> ok)
        else $error("found_position set on a failed word");

    // A failed request never carries a value.
    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> (result_value == '0))
        else $error("failed word carries a value");

    // While a response word waits, no new request may enter.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("request taken while response word is stalled");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(entry_count) && $stable(ok))
        else $error("stalled response word changed");

endmodule

bind positional_ordered_list pol_check u_pol_check (.*);

[bench/positional_ordered_list_test.sv]
// Self-checking testbench for the positional ordered list block.
// Uses pol_pkg for the request codes and widths and instantiates positional_ordered_list.
// A directed table runs first, then random grow and shrink traffic is checked by a shadow list.
module positional_ordered_list_test;
    import pol_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
    localparam int NUM_DIRECTED = 24;
    localparam int RANDOM_WORDS = 1000;
    localparam int DRAIN_CYCLES = CAPACITY_DEF + 8;
    localparam int TIME_LIMIT   = 2000000;

    typedef struct packed {
        logic                   ok;
        logic [VALUE_W-1:0]     rv;
        logic [COUNT_OUT_W-1:0] fp;
        logic [COUNT_OUT_W-1:0] cnt;
    } rsp_word_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        logic               typed;
        rsp_word_t          rsp;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      req_stall;
    logic [REQ_W-1:0]          req_type = '0;
    logic [POS_W-1:0]          position = '0;
    logic signed [VALUE_W-1:0] value = '0;
    logic                      rsp_valid;
    logic                      rsp_stall = 1'b0;
    logic                      ok;
    logic signed [VALUE_W-1:0] result_value;
    logic [COUNT_OUT_W-1:0]    found_position;
    logic [COUNT_OUT_W-1:0]    entry_count;

    // Shadow copy of the list contents, positions 1..shadow_count.
    logic [VALUE_W-1:0] shadow_list [CAPACITY_DEF];
    int                 shadow_count = 0;

    rsp_word_t expected_rsp [$];
    stim_row_t directed_rows [NUM_DIRECTED];

    int  err_count      = 0;
    int  send_idle_pct  = 0;
    int  rsp_stall_pct  = 0;
    int  words_accepted = 0;
    int  full_rejects   = 0;
    int  peak_fill      = 0;
    int  finds_hit      = 0;
    bit  growing        = 1'b1;

    positional_ordered_list uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .position       (position),
        .value          (value),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .ok             (ok),
        .result_value   (result_value),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Applies one request to the shadow list and returns the response word it should give.
    function automatic rsp_word_t apply_request(input logic [REQ_W-1:0] rt,
                                                input logic [POS_W-1:0] pos,
                                                input logic [VALUE_W-1:0] val);
        rsp_word_t r;
        int        p;
        r = '0;
        p = int'(pos);
        case (rt)
            REQ_INSERT:
            begin
                if (p >= 1 && p <= shadow_count + 1 && shadow_count < CAPACITY_DEF)
                begin
                    for (int k = shadow_count; k >= p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1] = val;
                    shadow_count++;
                    r.ok = 1'b1;
                end
                else if (shadow_count == CAPACITY_DEF)
                    full_rejects++;
            end
            REQ_DELETE:
            begin
                if (p >= 1 && p <= shadow_count)
                begin
                    r.rv = shadow_list[p-1];
                    for (int k = p; k < shadow_count; k++)
                        shadow_list[k-1] = shadow_list[k];
                    shadow_count--;
                    r.ok = 1'b1;
                end
            end
            REQ_FIND:
            begin
                for (int k = 0; k < shadow_count; k++)
                begin
                    if (!r.ok && shadow_list[k] == val)
                    begin
                        r.ok = 1'b1;
                        r.fp = COUNT_OUT_W'(k + 1);
                    end
                end
                if (r.ok)
                    finds_hit++;
            end
            REQ_READ:
            begin
                if (p >= 1 && p <= shadow_count)
                begin
                    r.rv = shadow_list[p-1];
                    r.ok = 1'b1;
                end
            end
            REQ_APPEND:
            begin
                if (shadow_count < CAPACITY_DEF)
                begin
                    shadow_list[shadow_count] = val;
                    shadow_count++;
                    r.ok = 1'b1;
                end
                else
                    full_rejects++;
            end
            default:
            begin
            end
        endcase
        r.cnt = COUNT_OUT_W'(shadow_count);
        if (shadow_count > peak_fill)
            peak_fill = shadow_count;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
                                         input logic [VALUE_W-1:0] val, input logic typed,
                                         input logic rok, input logic [VALUE_W-1:0] rrv,
                                         input logic [COUNT_OUT_W-1:0] rfp,
                                         input logic [COUNT_OUT_W-1:0] rcnt);
        stim_row_t s;
        s.req       = rt;
        s.pos       = pos;
        s.val       = val;
        s.typed     = typed;
        s.rsp.ok    = rok;
        s.rsp.rv    = rrv;
        s.rsp.fp    = rfp;
        s.rsp.cnt   = rcnt;
        return s;
    endfunction

    // Small pool values make duplicates, so find has to pick the first of several matches.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return VALUE_W'($urandom_range(7)) - VALUE_W'(3);
        else if (r < 50)
            return ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else if (r < 70 && shadow_count > 0)
            return shadow_list[$urandom_range(shadow_count - 1)];
        else
            return $urandom;
    endfunction

    task automatic make_random_word(output logic [REQ_W-1:0] rt, output logic [POS_W-1:0] pos,
                                    output logic [VALUE_W-1:0] val);
        int r;
        int sel;
        if (growing && shadow_count == CAPACITY_DEF && $urandom_range(3) == 0)
            growing = 1'b0;
        else if (!growing && shadow_count == 0 && $urandom_range(3) == 0)
            growing = 1'b1;
        else if ($urandom_range(99) < 2)
            growing = !growing;
        r = $urandom_range(99);
        val = pick_value();
        if (r < 4)
        begin
            rt  = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
            pos = POS_W'($urandom);
            val = $urandom;
        end
        else if (r < 10)
        begin
            // Broken words: position zero, just past the end, or anything at all.
            rt = REQ_W'($urandom_range(REQ_APPEND, REQ_INSERT));
            case ($urandom_range(2))
                0: pos = '0;
                1: pos = POS_W'(shadow_count + 1 + $urandom_range(2));
                default: pos = POS_W'($urandom);
            endcase
            if ($urandom_range(1) != 0)
                val = $urandom;
        end
        else
        begin
            sel = $urandom_range(99);
            if (growing)
                rt = (sel < 45) ? REQ_INSERT : (sel < 70) ? REQ_APPEND :
                     (sel < 80) ? REQ_FIND : (sel < 90) ? REQ_READ : REQ_DELETE;
            else
                rt = (sel < 45) ? REQ_DELETE : (sel < 55) ? REQ_INSERT :
                     (sel < 60) ? REQ_APPEND : (sel < 80) ? REQ_FIND : REQ_READ;
            if (rt == REQ_INSERT)
                pos = POS_W'($urandom_range(shadow_count + 1, 1));
            else if (shadow_count > 0)
                pos = POS_W'($urandom_range(shadow_count, 1));
            else
                pos = POS_W'(1);
            if (rt == REQ_FIND && shadow_count > 0 && $urandom_range(9) < 7)
                val = shadow_list[$urandom_range(shadow_count - 1)];
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word was taken.
    task automatic send_word(input logic [REQ_W-1:0] rt, input logic [POS_W-1:0] pos,
                             input logic [VALUE_W-1:0] val, input logic typed,
                             input rsp_word_t typed_rsp);
        int        gap;
        rsp_word_t want;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rt;
        position  <= pos;
        value     <= val;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        want = apply_request(rt, pos, val);
        if (typed)
            want = typed_rsp;
        expected_rsp.push_back(want);
        words_accepted++;
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        req_valid <= 1'b0;
        @(negedge clk);
        while (expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        rsp_stall <= rst_n && ($urandom_range(99) < rsp_stall_pct);

    always @(posedge clk)
    begin : rsp_check
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch("response word with nothing outstanding", 64'(ok), 64'd0);
            else
            begin
                want = expected_rsp[0];
                expected_rsp.delete(0);
                if (ok !== want.ok)
                    report_mismatch("ok", 64'(ok), 64'(want.ok));
                if (result_value !== want.rv)
                    report_mismatch("result_value", 64'(result_value), 64'(want.rv));
                if (found_position !== want.fp)
                    report_mismatch("found_position", 64'(found_position), 64'(want.fp));
                if (entry_count !== want.cnt)
                    report_mismatch("entry_count", 64'(entry_count), 64'(want.cnt));
            end
        end
    end

    initial
    begin : stimulus
        logic [REQ_W-1:0]   rt;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        int                 real_words;

        directed_rows = '{
            mk_row(REQ_READ,   8'd1,   32'h0,         1'b1, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_DELETE, 8'd0,   32'h0,         1'b1, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_FIND,   8'd0,   32'h0,         1'b1, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_INSERT, 8'd2,   32'h5,         1'b1, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_INSERT, 8'd0,   32'h5,         1'b1, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_INSERT, 8'd1,   32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd0, 7'd1),
            mk_row(REQ_APPEND, 8'd0,   32'h8000_0000, 1'b1, 1'b1, 32'h0, 7'd0, 7'd2),
            mk_row(REQ_INSERT, 8'd3,   32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0, 7'd0, 7'd3),
            mk_row(REQ_INSERT, 8'd1,   32'h0,         1'b1, 1'b1, 32'h0, 7'd0, 7'd4),
            mk_row(REQ_READ,   8'd4,   32'h0,         1'b0, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_READ,   8'd5,   32'h0,         1'b1, 1'b0, 32'h0, 7'd0, 7'd4),
            mk_row(REQ_FIND,   8'd0,   32'h8000_0000, 1'b0, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_FIND,   8'd0,   32'd12345,     1'b1, 1'b0, 32'h0, 7'd0, 7'd4),
            mk_row(REQ_DELETE, 8'd5,   32'h0,         1'b1, 1'b0, 32'h0, 7'd0, 7'd4),
            mk_row(REQ_DELETE, 8'd4,   32'h0,         1'b0, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_UNUSED_LO, 8'd1, 32'h0,        1'b1, 1'b0, 32'h0, 7'd0, 7'd3),
            mk_row(REQ_UNUSED_HI, 8'd255, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 7'd0, 7'd3),
            mk_row(REQ_READ,   8'd255, 32'h0,         1'b1, 1'b0, 32'h0, 7'd0, 7'd3),
            mk_row(REQ_INSERT, 8'd255, 32'h1,         1'b1, 1'b0, 32'h0, 7'd0, 7'd3),
            mk_row(REQ_APPEND, 8'd0,   32'h0,         1'b0, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_FIND,   8'd0,   32'h0,         1'b0, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_DELETE, 8'd1,   32'h0,         1'b0, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_READ,   8'd1,   32'h0,         1'b0, 1'b0, 32'h0, 7'd0, 7'd0),
            mk_row(REQ_FIND,   8'd0,   32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 7'd0, 7'd0)
        };

        send_idle_pct = 10;
        rsp_stall_pct = 68;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].req, directed_rows[i].pos, directed_rows[i].val,
                      directed_rows[i].typed, directed_rows[i].rsp);

        // Three idling regimes; the sender drains the block before each one.
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 68 : 0;
            rsp_stall_pct = (ph == 0) ? 68 : (ph == 1) ? 10 : 0;
            wait_until_drained();
            real_words = 0;
            while (real_words < RANDOM_WORDS / 3)
            begin
                make_random_word(rt, pos, val);
                send_word(rt, pos, val, 1'b0, '0);
                if (rt <= REQ_APPEND)
                    real_words++;
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rsp.size() != 0)
            report_mismatch("response words never delivered", 64'(expected_rsp.size()), 64'd0);

        $display("Covered %0d request words, peak fill %0d of %0d entries,",
                 words_accepted, peak_fill, CAPACITY_DEF);
        $display("%0d requests refused on a full list and %0d finds that hit; %0d mismatches.",
                 full_rejects, finds_hit, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #(TIME_LIMIT);
        $display("Timeout with %0d response words outstanding.", expected_rsp.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
